// ===== rtl/mse_pkg.sv =====
// Shared constants, codes and types of the instruction executor.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

    localparam int DATA_WORDS = 256;
    localparam int PC_BITS    = 16;
    localparam int DM_AW      = $clog2(DATA_WORDS);
    localparam int RF_DEPTH   = 32;
    localparam int RF_AW      = $clog2(RF_DEPTH);
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [5:0] OP_LW   = 6'b100011;
    localparam logic [5:0] OP_SW   = 6'b101011;
    localparam logic [5:0] OP_ADDI = 6'b001000;
    localparam logic [5:0] OP_BEQ  = 6'b000100;
    localparam logic [5:0] OP_RTYP = 6'b000000;
    localparam logic [5:0] OP_JMP  = 6'b000010;
    localparam logic [5:0] FN_SUB  = 6'b100010;
    localparam logic [5:0] FN_MUL  = 6'b011000;

    localparam logic [1:0] REQ_EXEC = 2'd0;
    localparam logic [1:0] REQ_HWR  = 2'd1;
    localparam logic [1:0] REQ_HRD  = 2'd2;

    typedef enum logic [3:0] {
        K_LW,
        K_SW,
        K_ADDI,
        K_BEQ,
        K_SUB,
        K_MUL,
        K_JMP,
        K_ILL,
        K_HWR,
        K_HRD,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              wen;
        logic [RF_AW-1:0]  dst;
        logic [RF_AW-1:0]  src_a;
        logic [RF_AW-1:0]  src_b;
        logic [25:0]       off;
        logic [7:0]        haddr;
        logic [31:0]       hdata;
    } dec_t;

    typedef struct packed {
        logic valid;
        dec_t item;
    } qhead_t;

endpackage
`default_nettype wire

// ===== rtl/mse_req_if.sv =====
// Request channel: one item per instruction or host access.
`timescale 1ns / 1ps
`default_nettype none
interface mse_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [31:0]        instr_word;
    logic [7:0]         host_addr;
    logic signed [31:0] host_data;

    modport source (output valid, output req_type, output instr_word,
                    output host_addr, output host_data, input ready);
    modport sink   (input valid, input req_type, input instr_word,
                    input host_addr, input host_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mse_rsp_if.sv =====
// Result channel: one item per accepted request.
`timescale 1ns / 1ps
`default_nettype none
interface mse_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pc_after;
    logic signed [31:0] read_word;
    logic               illegal;

    modport source (output valid, output pc_after, output read_word,
                    output illegal, input ready);
    modport sink   (input valid, input pc_after, input read_word,
                    input illegal, output ready);
endinterface
`default_nettype wire

// ===== rtl/mse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mse_front.sv =====
// Front end: accepts items, classifies them and queues them for execution.
`timescale 1ns / 1ps
`default_nettype none
module mse_front
    import mse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mse_req_if.sink       req,
    output qhead_t        head,
    input  logic          pop
);

    dec_t            dec;
    logic [5:0]      op;
    logic [5:0]      fn;
    logic            push;
    dec_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    assign op = req.instr_word[31:26];
    assign fn = req.instr_word[5:0];

    always_comb
    begin
        dec.kind  = K_NOP;
        dec.dst   = req.instr_word[25:21];
        dec.src_a = req.instr_word[20:16];
        dec.src_b = req.instr_word[25:21];
        dec.off   = req.instr_word[25:0];
        dec.haddr = req.host_addr;
        dec.hdata = req.host_data;
        unique case (req.req_type)
            REQ_EXEC:
            begin
                unique case (op)
                    OP_LW:   dec.kind = K_LW;
                    OP_SW:   dec.kind = K_SW;
                    OP_ADDI: dec.kind = K_ADDI;
                    OP_BEQ:  dec.kind = K_BEQ;
                    OP_JMP:  dec.kind = K_JMP;
                    OP_RTYP:
                    begin
                        unique case (fn)
                            FN_SUB:  dec.kind = K_SUB;
                            FN_MUL:  dec.kind = K_MUL;
                            default: dec.kind = K_ILL;
                        endcase
                    end
                    default: dec.kind = K_ILL;
                endcase
            end
            REQ_HWR: dec.kind = K_HWR;
            REQ_HRD: dec.kind = K_HRD;
            default: dec.kind = K_NOP;
        endcase
        if (dec.kind == K_SUB || dec.kind == K_MUL)
        begin
            dec.src_b = req.instr_word[15:11];
        end
        dec.wen = (dec.kind == K_LW || dec.kind == K_ADDI || dec.kind == K_SUB
                   || dec.kind == K_MUL) && (dec.dst != '0);
    end

    // two-entry queue toward the back end
    assign req.ready = (count_reg != Q_CW'(Q_DEPTH));
    assign push      = req.valid && req.ready;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ===== rtl/mse_back.sv =====
// Back end: register read, execute with memory access, and result register.
`timescale 1ns / 1ps
`default_nettype none
module mse_back
    import mse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  qhead_t        head,
    output logic          pop,
    mse_rsp_if.source     rsp
);

    logic                adv;
    // execute stage
    logic                x_valid_reg;
    dec_t                x_item_reg;
    logic                rfa_vld_reg;
    logic                rfb_vld_reg;
    logic [31:0]         rfa_q;
    logic [31:0]         rfb_q;
    logic [31:0]         opa;
    logic [31:0]         opb;
    logic [31:0]         imm32;
    logic [31:0]         joff32;
    logic [31:0]         sum_addr;
    logic [63:0]         prod_full;
    logic [31:0]         res;
    logic [31:0]         haddr32;
    logic [DM_AW-1:0]    dm_addr;
    logic                dm_we;
    logic [31:0]         dm_wdata;
    logic [31:0]         dm_q;
    logic                dm_vld_q_reg;
    logic [31:0]         dm_val;
    logic [DATA_WORDS-1:0] dm_valid_reg;
    logic [PC_BITS-1:0]  pc_reg;
    logic [PC_BITS-1:0]  pc_next;
    logic [31:0]         pc_ext;
    logic                x_upd;
    // result stage
    logic                w_valid_reg;
    logic                w_wen_reg;
    logic [RF_AW-1:0]    w_dst_reg;
    logic                w_load_reg;
    logic                w_hrd_reg;
    logic                w_ill_reg;
    logic [31:0]         w_res_reg;
    logic [15:0]         w_pc_reg;
    logic [31:0]         w_wdata;
    logic                rf_we;
    logic [RF_DEPTH-1:0] rf_valid_reg;
    // last retired register write
    logic                w2_wen_reg;
    logic [RF_AW-1:0]    w2_dst_reg;
    logic [31:0]         w2_data_reg;

    assign adv   = !w_valid_reg || rsp.ready;
    assign pop   = adv && head.valid;
    assign rf_we = adv && w_valid_reg && w_wen_reg;
    assign x_upd = adv && x_valid_reg;

    mse_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (w_dst_reg),
        .wdata (w_wdata),
        .re    (adv),
        .raddr (head.item.src_a),
        .rdata (rfa_q)
    );

    mse_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (w_dst_reg),
        .wdata (w_wdata),
        .re    (adv),
        .raddr (head.item.src_b),
        .rdata (rfb_q)
    );

    mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_addr),
        .wdata (dm_wdata),
        .re    (adv),
        .raddr (dm_addr),
        .rdata (dm_q)
    );

    assign dm_val  = dm_vld_q_reg ? dm_q : '0;
    assign w_wdata = w_load_reg ? dm_val : w_res_reg;

    // operand bypass: result stage first, then last retired write
    always_comb
    begin
        if (w_valid_reg && w_wen_reg && w_dst_reg == x_item_reg.src_a)
        begin
            opa = w_wdata;
        end
        else if (w2_wen_reg && w2_dst_reg == x_item_reg.src_a)
        begin
            opa = w2_data_reg;
        end
        else
        begin
            opa = rfa_vld_reg ? rfa_q : '0;
        end
        if (w_valid_reg && w_wen_reg && w_dst_reg == x_item_reg.src_b)
        begin
            opb = w_wdata;
        end
        else if (w2_wen_reg && w2_dst_reg == x_item_reg.src_b)
        begin
            opb = w2_data_reg;
        end
        else
        begin
            opb = rfb_vld_reg ? rfb_q : '0;
        end
    end

    assign imm32     = {{16{x_item_reg.off[15]}}, x_item_reg.off[15:0]};
    assign joff32    = {{6{x_item_reg.off[25]}}, x_item_reg.off};
    assign sum_addr  = opa + imm32;
    assign prod_full = opa * opb;
    assign haddr32   = {24'd0, x_item_reg.haddr};

    always_comb
    begin
        res      = opa - opb;
        dm_addr  = sum_addr[DM_AW-1:0];
        dm_we    = 1'b0;
        dm_wdata = opb;
        pc_next  = pc_reg;
        unique case (x_item_reg.kind)
            K_LW:
            begin
                pc_next = pc_reg + 1'b1;
            end
            K_SW:
            begin
                dm_we   = x_upd;
                pc_next = pc_reg + 1'b1;
            end
            K_ADDI:
            begin
                res     = sum_addr;
                pc_next = pc_reg + 1'b1;
            end
            K_SUB:
            begin
                pc_next = pc_reg + 1'b1;
            end
            K_MUL:
            begin
                res     = prod_full[31:0];
                pc_next = pc_reg + 1'b1;
            end
            K_BEQ:
            begin
                if (opb == {27'd0, x_item_reg.src_a})
                begin
                    pc_next = pc_reg + imm32[PC_BITS-1:0];
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            K_JMP:
            begin
                pc_next = pc_reg + joff32[PC_BITS-1:0];
            end
            K_HWR:
            begin
                dm_addr  = haddr32[DM_AW-1:0];
                dm_we    = x_upd;
                dm_wdata = x_item_reg.hdata;
            end
            K_HRD:
            begin
                dm_addr = haddr32[DM_AW-1:0];
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    assign pc_ext = 32'(pc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            w2_wen_reg   <= 1'b0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
            dm_valid_reg <= '0;
            rfa_vld_reg  <= 1'b0;
            rfb_vld_reg  <= 1'b0;
            dm_vld_q_reg <= 1'b0;
        end
        else if (adv)
        begin
            x_valid_reg  <= head.valid;
            rfa_vld_reg  <= rf_valid_reg[head.item.src_a];
            rfb_vld_reg  <= rf_valid_reg[head.item.src_b];
            dm_vld_q_reg <= dm_valid_reg[dm_addr];
            w_valid_reg  <= x_valid_reg;
            w2_wen_reg   <= w_valid_reg && w_wen_reg;
            if (x_valid_reg)
            begin
                pc_reg <= pc_next;
            end
            if (dm_we)
            begin
                dm_valid_reg[dm_addr] <= 1'b1;
            end
            if (rf_we)
            begin
                rf_valid_reg[w_dst_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_item_reg  <= head.item;
            w_wen_reg   <= x_item_reg.wen;
            w_dst_reg   <= x_item_reg.dst;
            w_load_reg  <= (x_item_reg.kind == K_LW);
            w_hrd_reg   <= (x_item_reg.kind == K_HRD);
            w_ill_reg   <= (x_item_reg.kind == K_ILL);
            w_res_reg   <= res;
            w_pc_reg    <= pc_ext[15:0];
            w2_dst_reg  <= w_dst_reg;
            w2_data_reg <= w_wdata;
        end
    end

    assign rsp.valid     = w_valid_reg;
    assign rsp.pc_after  = w_pc_reg;
    assign rsp.read_word = w_hrd_reg ? dm_val : '0;
    assign rsp.illegal   = w_ill_reg;

endmodule
`default_nettype wire

// ===== rtl/mips_subset_instruction_executor.sv =====
// Top level of the MIPS-subset instruction executor.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock while the result side is ready and returns one result
// item per request, in order. An item waits at the head of a two-entry classify
// queue while the register file is read, then passes through the execute stage
// (address add, ALU or 32x32 multiply, data memory access, program counter
// update) and lands in the output register, with one item per cycle sustained
// while the result side is ready. Back-to-back register dependences are bypassed
// from the result stage and from the last retired write, so no dependence stalls.
// The register file (two copies for two read ports) and the data memory are RAMs;
// per-entry valid flops make them read as zero after reset, so no clearing pass
// is needed and the block is ready right after reset.
module mips_subset_instruction_executor
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mse_req_if.sink   req,
    mse_rsp_if.source rsp
);

    qhead_t head;
    logic   pop;

    mse_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    mse_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> head.valid)
        else $error("accepted item missing from queue");

    a_illegal_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.illegal) |-> (rsp.read_word == '0))
        else $error("illegal result carries read data");

endmodule
`default_nettype wire
